[rtl/core/tsst_pkg.sv]
// Shared types and codes of the TCP session state table.
package tsst_pkg;

  // Request codes carried in the func field.
  localparam logic [2:0] F_TX_ACCEPT = 3'd0;
  localparam logic [2:0] F_TX_STREAM = 3'd1;
  localparam logic [2:0] F_RX        = 3'd2;
  localparam logic [2:0] F_CLOSE     = 3'd3;
  localparam logic [2:0] F_IDLE      = 3'd4;

  // Result kinds.
  localparam logic [2:0] K_ACCEPT  = 3'd0;
  localparam logic [2:0] K_STREAM  = 3'd1;
  localparam logic [2:0] K_RX      = 3'd2;
  localparam logic [2:0] K_RELEASE = 3'd3;
  localparam logic [2:0] K_REFUSED = 3'd4;

  // Connection state meaning the session is closed.
  localparam logic [3:0] CLOSED = 4'd0;

  // One request as it sits in the input register.
  typedef struct packed {
    logic [2:0] func;
    logic [9:0] session_id;
    logic       is_write;
    logic [3:0] new_state;
  } req_t;

  // Table access and result decided for one request.
  typedef struct packed {
    logic       emit;
    logic [2:0] kind;
    logic [9:0] session;
    logic       rd;
    logic       wr;
    logic [3:0] wdata;
  } acc_t;

endpackage

[rtl/core/tcp_session_state_table.sv]
// Top level: TCP session state table with per-side session locks.
// Path: input register, then result register beside the registered RAM read data.
// Throughput: one request per cycle while not clearing and m_tready does not stall;
// each request reads or writes the table at most once. Reset: synchronous; locks and
// parked accesses clear at once, then a clearing pass writes CLOSED to all SESSIONS
// entries, one a cycle, while s_tready stays low.
module tcp_session_state_table
  import tsst_pkg::*;
#(
  parameter int SESSIONS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [9:0] session_id, [10] is_write, [14:11] new_state, rest zero
  input  logic [15:0] s_tdata,
  // [2:0] func
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [9:0] out_session, [13:10] state_value, rest zero
  output logic [15:0] m_tdata,
  // [2:0] kind
  output logic [2:0]  m_tuser
);

  localparam int AW = $clog2(SESSIONS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(SESSIONS - 1);
  // Reciprocal for taking the table slot of a 10-bit session number.
  localparam logic [19:0] RECIP = 20'((1 << 20) / SESSIONS);
  localparam logic [10:0] N_LOW = 11'(SESSIONS);
  localparam logic [16:0] N_FULL = 17'(SESSIONS);

  // Clearing pass.
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // Input register.
  logic       s1_valid;
  req_t       s1_req;
  logic [9:0] s1_quot;

  // Result register.
  logic       s2_valid;
  logic [2:0] s2_kind;
  logic [9:0] s2_session;
  logic       s2_use_ram;

  logic [29:0]   quot_prod;
  logic [10:0]   rem;
  logic [16:0]   rem_fix;
  logic [AW-1:0] s1_slot;
  logic          s1_fire;
  acc_t          acc;
  logic [AW-1:0] acc_slot;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [3:0]    ram_wr_data;
  logic          ram_rd_en;
  logic [3:0]    ram_rd_data;
  logic [3:0]    state_value;

  // Handshake and advance of the input register.
  assign s1_fire  = s1_valid && (!s2_valid || m_tready);
  assign s_tready = !clearing && (!s1_valid || s1_fire);

  // Quotient estimate of session / SESSIONS, taken at the transfer.
  assign quot_prod = {20'b0, s_tdata[9:0]} * {10'b0, RECIP};

  // Remainder with one correction step gives the table slot.
  assign rem     = {1'b0, s1_req.session_id} - 11'(s1_quot * N_LOW);
  assign rem_fix = ({6'b0, rem} >= N_FULL) ? {6'b0, rem} - N_FULL : {6'b0, rem};
  assign s1_slot = rem_fix[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_SLOT) begin
        clearing <= 1'b0;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_req.func       <= s_tuser;
      s1_req.session_id <= s_tdata[9:0];
      s1_req.is_write   <= s_tdata[10];
      s1_req.new_state  <= s_tdata[14:11];
      s1_quot           <= quot_prod[29:20];
    end
  end

  tsst_lock #(
    .AW (AW)
  ) u_lock (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_fire),
    .req      (s1_req),
    .req_slot (s1_slot),
    .acc      (acc),
    .acc_slot (acc_slot)
  );

  // Table port sharing between the clearing pass and requests.
  assign ram_wr_en   = clearing || (s1_fire && acc.wr);
  assign ram_wr_addr = clearing ? clr_addr : acc_slot;
  assign ram_wr_data = clearing ? CLOSED : acc.wdata;
  assign ram_rd_en   = s1_fire && acc.rd;

  tsst_ram #(
    .WIDTH (4),
    .DEPTH (SESSIONS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (acc_slot),
    .rd_data (ram_rd_data)
  );

  // Result register; the read data of the RAM holds alongside it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_fire) begin
      s2_valid <= acc.emit;
    end else if (m_tready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_kind    <= acc.kind;
      s2_session <= acc.session;
      s2_use_ram <= acc.rd;
    end
  end

  assign state_value = s2_use_ram ? ram_rd_data : CLOSED;
  assign m_tvalid    = s2_valid;
  assign m_tdata     = {2'b0, state_value, s2_session};
  assign m_tuser     = s2_kind;

  // No request transfer during the clearing pass.
  assert property (@(posedge clk) disable iff (rst) clearing |-> !s_tready)
    else $error("request taken while clearing");

  // A table read is only issued when the result register takes its result.
  assert property (@(posedge clk) disable iff (rst)
    ram_rd_en |-> (!s2_valid || m_tready))
    else $error("table read would overwrite held read data");

  // A request never both reads and writes the table.
  assert property (@(posedge clk) disable iff (rst) s1_fire |-> !(acc.rd && acc.wr))
    else $error("request reads and writes the table");

endmodule

[rtl/core/tsst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tsst_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/tsst_lock.sv]
// Session locks, parked accesses and the per-request access decision.
module tsst_lock
  import tsst_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  req_t          req,
  input  logic [AW-1:0] req_slot,
  output acc_t          acc,
  output logic [AW-1:0] acc_slot
);

  // Lock registers.
  logic       rx_locked;
  logic [9:0] rx_lock_session;
  logic       tx_locked;
  logic [9:0] tx_lock_session;

  // Parked accesses, one per source.
  logic          tx_parked;
  logic [9:0]    tx_pq_session;
  logic [AW-1:0] tx_pq_slot;
  logic          tx_pq_write;
  logic [3:0]    tx_pq_state;
  logic          rx_parked;
  logic [9:0]    rx_pq_session;
  logic [AW-1:0] rx_pq_slot;
  logic          rx_pq_write;
  logic [3:0]    rx_pq_state;
  logic          close_parked;
  logic [9:0]    close_pq_session;
  logic [AW-1:0] close_pq_slot;

  // Decision outputs.
  logic          park_tx, park_rx, park_close;
  logic          unpark_tx, unpark_rx, unpark_close;
  logic          do_tx, do_rx, do_close;
  logic          lock_tx, unlock_tx, lock_rx, unlock_rx;
  logic [9:0]    op_session;
  logic [AW-1:0] op_slot;
  logic          op_write;
  logic [3:0]    op_state;

  // Choose what the request does, then carry out the chosen access.
  always_comb begin
    park_tx      = 1'b0;
    park_rx      = 1'b0;
    park_close   = 1'b0;
    unpark_tx    = 1'b0;
    unpark_rx    = 1'b0;
    unpark_close = 1'b0;
    do_tx        = 1'b0;
    do_rx        = 1'b0;
    do_close     = 1'b0;
    lock_tx      = 1'b0;
    unlock_tx    = 1'b0;
    lock_rx      = 1'b0;
    unlock_rx    = 1'b0;
    op_session   = req.session_id;
    op_slot      = req_slot;
    op_write     = req.is_write;
    op_state     = req.new_state;
    acc          = '0;
    acc.session  = req.session_id;
    case (req.func)
      F_TX_ACCEPT: begin
        if (tx_parked) begin
          acc.emit = 1'b1;
          acc.kind = K_REFUSED;
        end else if (rx_locked && req.session_id == rx_lock_session) begin
          park_tx = 1'b1;
        end else begin
          do_tx = 1'b1;
        end
      end
      F_TX_STREAM: begin
        acc.emit = 1'b1;
        acc.kind = K_STREAM;
        acc.rd   = 1'b1;
      end
      F_RX: begin
        if (rx_parked) begin
          acc.emit = 1'b1;
          acc.kind = K_REFUSED;
        end else if (tx_locked && req.session_id == tx_lock_session) begin
          park_rx = 1'b1;
        end else begin
          do_rx = 1'b1;
        end
      end
      F_CLOSE: begin
        if (close_parked) begin
          acc.emit = 1'b1;
          acc.kind = K_REFUSED;
        end else if ((rx_locked && req.session_id == rx_lock_session) ||
                     (tx_locked && req.session_id == tx_lock_session)) begin
          park_close = 1'b1;
        end else begin
          do_close = 1'b1;
        end
      end
      F_IDLE: begin
        // Only the first parked access is retried.
        if (tx_parked) begin
          op_session = tx_pq_session;
          op_slot    = tx_pq_slot;
          op_write   = tx_pq_write;
          op_state   = tx_pq_state;
          if (!(rx_locked && tx_pq_session == rx_lock_session)) begin
            unpark_tx = 1'b1;
            do_tx     = 1'b1;
          end
        end else if (rx_parked) begin
          op_session = rx_pq_session;
          op_slot    = rx_pq_slot;
          op_write   = rx_pq_write;
          op_state   = rx_pq_state;
          if (!(tx_locked && rx_pq_session == tx_lock_session)) begin
            unpark_rx = 1'b1;
            do_rx     = 1'b1;
          end
        end else if (close_parked) begin
          op_session = close_pq_session;
          op_slot    = close_pq_slot;
          if (!((rx_locked && close_pq_session == rx_lock_session) ||
                (tx_locked && close_pq_session == tx_lock_session))) begin
            unpark_close = 1'b1;
            do_close     = 1'b1;
          end
        end
      end
      default: begin
        acc.emit = 1'b0;
      end
    endcase

    // Carry out an unblocked access.
    if (do_tx) begin
      acc.session = op_session;
      if (op_write) begin
        acc.wr    = 1'b1;
        acc.wdata = op_state;
        unlock_tx = 1'b1;
      end else begin
        acc.emit = 1'b1;
        acc.kind = K_ACCEPT;
        acc.rd   = 1'b1;
        lock_tx  = 1'b1;
      end
    end
    if (do_rx) begin
      acc.session = op_session;
      if (op_write) begin
        acc.wr    = 1'b1;
        acc.wdata = op_state;
        unlock_rx = 1'b1;
        if (op_state == CLOSED) begin
          acc.emit = 1'b1;
          acc.kind = K_RELEASE;
        end
      end else begin
        acc.emit = 1'b1;
        acc.kind = K_RX;
        acc.rd   = 1'b1;
        lock_rx  = 1'b1;
      end
    end
    if (do_close) begin
      acc.session = op_session;
      acc.wr      = 1'b1;
      acc.wdata   = CLOSED;
      acc.emit    = 1'b1;
      acc.kind    = K_RELEASE;
    end
    acc_slot = op_slot;
  end

  // Lock and park flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_locked       <= 1'b0;
      rx_lock_session <= '0;
      tx_locked       <= 1'b0;
      tx_lock_session <= '0;
      tx_parked       <= 1'b0;
      rx_parked       <= 1'b0;
      close_parked    <= 1'b0;
    end else if (step) begin
      if (lock_tx) begin
        tx_locked       <= 1'b1;
        tx_lock_session <= op_session;
      end else if (unlock_tx) begin
        tx_locked <= 1'b0;
      end
      if (lock_rx) begin
        rx_locked       <= 1'b1;
        rx_lock_session <= op_session;
      end else if (unlock_rx) begin
        rx_locked <= 1'b0;
      end
      if (park_tx) begin
        tx_parked <= 1'b1;
      end else if (unpark_tx) begin
        tx_parked <= 1'b0;
      end
      if (park_rx) begin
        rx_parked <= 1'b1;
      end else if (unpark_rx) begin
        rx_parked <= 1'b0;
      end
      if (park_close) begin
        close_parked <= 1'b1;
      end else if (unpark_close) begin
        close_parked <= 1'b0;
      end
    end
  end

  // Parked request contents; only read while the matching flag is set.
  always_ff @(posedge clk) begin
    if (step && park_tx) begin
      tx_pq_session <= req.session_id;
      tx_pq_slot    <= req_slot;
      tx_pq_write   <= req.is_write;
      tx_pq_state   <= req.new_state;
    end
    if (step && park_rx) begin
      rx_pq_session <= req.session_id;
      rx_pq_slot    <= req_slot;
      rx_pq_write   <= req.is_write;
      rx_pq_state   <= req.new_state;
    end
    if (step && park_close) begin
      close_pq_session <= req.session_id;
      close_pq_slot    <= req_slot;
    end
  end

  // A read always comes with a result.
  assert property (@(posedge clk) disable iff (rst) step && acc.rd |-> acc.emit)
    else $error("table read without a result");

  // A refused request leaves the table alone.
  assert property (@(posedge clk) disable iff (rst)
    step && acc.emit && acc.kind == K_REFUSED |-> !acc.rd && !acc.wr)
    else $error("refused request touched the table");

  // A tx source that has parked an access cannot park a second one.
  assert property (@(posedge clk) disable iff (rst)
    tx_parked && step |-> !park_tx)
    else $error("second tx access parked");

endmodule

[verif/tcp_session_state_table_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the TCP session state table with a cycle-free predictor.
module tcp_session_state_table_test;
  import tsst_pkg::*;

  localparam int TABLE_SIZE = 1024;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_SHOWN = 10;
  localparam int RANDOM_PER_PHASE = 320;
  localparam logic [2:0] F_SPARE_FIRST = 3'd5;
  localparam logic [2:0] F_SPARE_LAST = 3'd7;
  localparam logic [3:0] STATE_LAST_NAMED = 4'd10;
  localparam logic [3:0] STATE_TOP = 4'd15;
  localparam logic [9:0] SESSION_TOP = 10'd1023;

  // One queued request, or a pause that waits for all replies and then changes the idling phase.
  typedef struct {
    bit         pause;
    int         phase;
    logic [2:0] func;
    logic [9:0] session;
    logic       is_write;
    logic [3:0] new_state;
  } request_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [9:0] session;
    logic [3:0] state;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [9:0] session_id, [10] is_write, [14:11] new_state, rest zero
  logic [15:0] s_tdata = '0;
  // [2:0] func
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [9:0] out_session, [13:10] state_value, rest zero
  logic [15:0] m_tdata;
  // [2:0] kind
  logic [2:0]  m_tuser;

  // Predicted table contents, locks and parked accesses.
  logic [3:0] conn_state [TABLE_SIZE];
  logic       tx_held = 1'b0;
  logic       rx_held = 1'b0;
  logic [9:0] tx_held_session = '0;
  logic [9:0] rx_held_session = '0;
  logic       tx_waiting = 1'b0;
  logic       rx_waiting = 1'b0;
  logic       close_waiting = 1'b0;
  request_t   tx_waiting_req;
  request_t   rx_waiting_req;
  logic [9:0] close_waiting_session = '0;

  reply_t     expected_replies [$];
  request_t   request_backlog [$];
  request_t   on_offer;
  logic [9:0] busy_sessions [4];
  int         queued_items = 0;
  int         mismatches = 0;
  bit         req_taken = 1'b0;
  int         idle_phase = 0;
  int         send_idle_pct [3] = '{33, 48, 0};
  int         recv_idle_pct [3] = '{48, 33, 0};

  tcp_session_state_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Free-running clock of 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void expect_reply(logic [2:0] kind, logic [9:0] session, logic [3:0] state);
    reply_t r;
    r.kind = kind;
    r.session = session;
    r.state = state;
    expected_replies.push_back(r);
  endfunction

  function automatic bit tx_blocked(logic [9:0] session);
    return rx_held && session == rx_held_session;
  endfunction

  function automatic bit rx_blocked(logic [9:0] session);
    return tx_held && session == tx_held_session;
  endfunction

  function automatic bit close_blocked(logic [9:0] session);
    return tx_blocked(session) || rx_blocked(session);
  endfunction

  // A tx accept access that no rx lock stands in the way of.
  function automatic void tx_access(request_t r);
    if (r.is_write) begin
      conn_state[r.session] = r.new_state;
      tx_held = 1'b0;
    end else begin
      expect_reply(K_ACCEPT, r.session, conn_state[r.session]);
      tx_held_session = r.session;
      tx_held = 1'b1;
    end
  endfunction

  // An rx access that no tx lock stands in the way of; writing CLOSED releases the session.
  function automatic void rx_access(request_t r);
    if (r.is_write) begin
      conn_state[r.session] = r.new_state;
      rx_held = 1'b0;
      if (r.new_state == CLOSED) expect_reply(K_RELEASE, r.session, '0);
    end else begin
      expect_reply(K_RX, r.session, conn_state[r.session]);
      rx_held_session = r.session;
      rx_held = 1'b1;
    end
  endfunction

  function automatic void close_session(logic [9:0] session);
    conn_state[session] = CLOSED;
    expect_reply(K_RELEASE, session, '0);
  endfunction

  // Applies one accepted request to the predicted table and queues the reply it causes.
  function automatic void update_session_table(request_t r);
    case (r.func)
      F_TX_ACCEPT: begin
        if (tx_waiting) expect_reply(K_REFUSED, r.session, '0);
        else if (tx_blocked(r.session)) begin
          tx_waiting = 1'b1;
          tx_waiting_req = r;
        end else tx_access(r);
      end
      F_TX_STREAM: expect_reply(K_STREAM, r.session, conn_state[r.session]);
      F_RX: begin
        if (rx_waiting) expect_reply(K_REFUSED, r.session, '0);
        else if (rx_blocked(r.session)) begin
          rx_waiting = 1'b1;
          rx_waiting_req = r;
        end else rx_access(r);
      end
      F_CLOSE: begin
        if (close_waiting) expect_reply(K_REFUSED, r.session, '0);
        else if (close_blocked(r.session)) begin
          close_waiting = 1'b1;
          close_waiting_session = r.session;
        end else close_session(r.session);
      end
      F_IDLE: begin
        // Only the first parked access is retried: tx, then rx, then close.
        if (tx_waiting) begin
          if (!tx_blocked(tx_waiting_req.session)) begin
            tx_waiting = 1'b0;
            tx_access(tx_waiting_req);
          end
        end else if (rx_waiting) begin
          if (!rx_blocked(rx_waiting_req.session)) begin
            rx_waiting = 1'b0;
            rx_access(rx_waiting_req);
          end
        end else if (close_waiting) begin
          if (!close_blocked(close_waiting_session)) begin
            close_waiting = 1'b0;
            close_session(close_waiting_session);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void queue_request(logic [2:0] f, logic [9:0] s, logic w, logic [3:0] st);
    request_t r;
    r.pause = 1'b0;
    r.phase = 0;
    r.func = f;
    r.session = s;
    r.is_write = w;
    r.new_state = st;
    request_backlog.push_back(r);
    queued_items++;
  endfunction

  function automatic void queue_pause(int phase);
    request_t r;
    r = '{pause: 1'b1, phase: phase, func: F_IDLE, session: '0, is_write: 1'b0, new_state: CLOSED};
    request_backlog.push_back(r);
  endfunction

  // Mostly CLOSED or a named state, now and then one of the codes above the named ones.
  function automatic logic [3:0] random_state();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 3) return CLOSED;
    if (pick == 9) return 4'($urandom_range(STATE_TOP, STATE_LAST_NAMED + 1));
    return 4'($urandom_range(STATE_LAST_NAMED, 1));
  endfunction

  function automatic logic [9:0] fresh_session();
    case ($urandom_range(5))
      0: return '0;
      1: return SESSION_TOP;
      default: return 10'($urandom_range(SESSION_TOP));
    endcase
  endfunction

  // A few busy sessions make the two sides collide on locks often.
  function automatic logic [9:0] pick_session();
    if ($urandom_range(99) < 85) return busy_sessions[$urandom_range(3)];
    return 10'($urandom_range(SESSION_TOP));
  endfunction

  function automatic void queue_random_item();
    logic [9:0] s;
    s = pick_session();
    case ($urandom_range(9))
      0, 1: queue_request(F_TX_ACCEPT, s, 1'($urandom_range(1)), random_state());
      2, 3: queue_request(F_RX, s, 1'($urandom_range(1)), random_state());
      4: queue_request(F_TX_STREAM, s, 1'($urandom_range(1)), 4'($urandom));
      5: queue_request(F_CLOSE, s, 1'($urandom_range(1)), 4'($urandom));
      8: queue_request(3'($urandom_range(F_SPARE_LAST)), 10'($urandom), 1'($urandom),
                       4'($urandom));
      default: queue_request(F_IDLE, s, 1'($urandom_range(1)), 4'($urandom));
    endcase
  endfunction

  // Read-then-write sessions of one side with other traffic in between, plus loose noise.
  task automatic queue_random_traffic(int count);
    logic [2:0] side;
    logic [9:0] s;
    int         target;
    target = queued_items + count;
    while (queued_items < target) begin
      if ($urandom_range(15) == 0) busy_sessions[$urandom_range(3)] = fresh_session();
      if ($urandom_range(9) < 7) begin
        side = $urandom_range(1) ? F_TX_ACCEPT : F_RX;
        s = pick_session();
        queue_request(side, s, 1'b0, random_state());
        repeat ($urandom_range(3)) queue_random_item();
        if ($urandom_range(9) == 0) s = pick_session();
        queue_request(side, s, 1'b1, random_state());
      end else begin
        queue_random_item();
      end
    end
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void report_wrong(string what, reply_t want, reply_t seen);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("%0t %s: expected kind %0d session %0d state %0d, got kind %0d session %0d state %0d",
               $time, what, want.kind, want.session, want.state,
               seen.kind, seen.session, seen.state);
  endfunction

  // Samples both handshakes at the rising edge.
  always @(posedge clk) begin
    reply_t seen;
    reply_t want;
    req_taken = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        seen.kind = m_tuser;
        seen.session = m_tdata[9:0];
        seen.state = m_tdata[13:10];
        if (expected_replies.size() == 0) begin
          report_wrong("reply with none pending", '0, seen);
        end else begin
          want = expected_replies.pop_front();
          if (seen.kind !== want.kind || seen.session !== want.session
              || seen.state !== want.state)
            report_wrong("wrong reply", want, seen);
        end
      end
      if (s_tvalid && s_tready) begin
        update_session_table(on_offer);
        req_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // Offers requests and drives the receiver's readiness at the falling edge.
  always @(negedge clk) begin
    bit present;
    present = 1'b0;
    if (!rst) begin
      if (s_tvalid && !req_taken) begin
        present = 1'b1;
      end else begin
        if (request_backlog.size() != 0 && request_backlog[0].pause
            && expected_replies.size() == 0) begin
          idle_phase = request_backlog[0].phase;
          void'(request_backlog.pop_front());
        end
        if (request_backlog.size() != 0 && !request_backlog[0].pause
            && $urandom_range(99) >= send_idle_pct[idle_phase]) begin
          on_offer = request_backlog.pop_front();
          present = 1'b1;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct[idle_phase]);
    end
    s_tvalid <= present;
    s_tdata <= {1'b0, on_offer.new_state, on_offer.is_write, on_offer.session};
    s_tuser <= on_offer.func;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    foreach (conn_state[i]) conn_state[i] = CLOSED;
    foreach (busy_sessions[i]) busy_sessions[i] = fresh_session();
    on_offer = '{pause: 1'b0, phase: 0, func: F_IDLE, session: '0, is_write: 1'b0,
                 new_state: CLOSED};

    // Directed part: locks, parking, refusals, retries and the unused codes.
    queue_request(F_TX_STREAM, '0, 1'b0, CLOSED);
    queue_request(F_TX_STREAM, SESSION_TOP, 1'b1, STATE_TOP);
    queue_request(F_TX_ACCEPT, 10'd5, 1'b1, STATE_TOP);
    queue_request(F_TX_ACCEPT, 10'd5, 1'b0, CLOSED);
    queue_request(F_RX, 10'd5, 1'b0, CLOSED);
    queue_request(F_RX, 10'd7, 1'b0, 4'd3);
    queue_request(F_IDLE, '0, 1'b0, CLOSED);
    queue_request(F_TX_STREAM, 10'd5, 1'b0, CLOSED);
    queue_request(F_CLOSE, 10'd5, 1'b0, CLOSED);
    queue_request(F_CLOSE, 10'd9, 1'b0, CLOSED);
    // A write drops the tx lock even though it names another session.
    queue_request(F_TX_ACCEPT, 10'd9, 1'b1, STATE_LAST_NAMED);
    queue_request(F_IDLE, '0, 1'b0, CLOSED);
    queue_request(F_IDLE, '0, 1'b0, CLOSED);
    queue_request(F_TX_ACCEPT, 10'd5, 1'b0, CLOSED);
    queue_request(F_TX_ACCEPT, 10'd1, 1'b0, CLOSED);
    queue_request(F_RX, 10'd3, 1'b1, CLOSED);
    queue_request(F_IDLE, '0, 1'b0, CLOSED);
    queue_request(F_IDLE, '0, 1'b0, CLOSED);
    queue_request(F_TX_ACCEPT, 10'd5, 1'b1, 4'd8);
    queue_request(F_IDLE, SESSION_TOP, 1'b1, STATE_TOP);
    queue_request(F_IDLE, '0, 1'b0, CLOSED);
    for (int f = F_SPARE_FIRST; f <= F_SPARE_LAST; f++)
      queue_request(3'(f), SESSION_TOP, 1'b1, STATE_TOP);
    queue_request(F_RX, SESSION_TOP, 1'b1, STATE_LAST_NAMED + 1);
    queue_request(F_RX, SESSION_TOP, 1'b0, CLOSED);
    queue_request(F_CLOSE, SESSION_TOP, 1'b1, STATE_TOP);
    queue_request(F_RX, SESSION_TOP, 1'b1, 4'd12);
    queue_request(F_IDLE, '0, 1'b0, CLOSED);
    queue_request(F_TX_STREAM, 10'd5, 1'b0, CLOSED);

    // Random part in three idling phases; the later two are entered once all replies are in.
    queue_random_traffic(RANDOM_PER_PHASE);
    queue_pause(1);
    queue_random_traffic(RANDOM_PER_PHASE);
    queue_pause(2);
    queue_random_traffic(RANDOM_PER_PHASE - 10);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_backlog.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tcp_session_state_table: match");
    end else begin
      $display("tcp_session_state_table: mismatch");
    end
    $finish;
  end

  // Ends a run that hangs, counting cycles from the start including the clearing pass.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tcp_session_state_table: mismatch");
    $finish;
  end

endmodule
